// ===== src/ptp_pkg.sv =====
// Shared widths and constants for the perspective point transform.
`default_nettype none
package ptp_pkg;
    localparam int CoordW   = 32;
    localparam int ProdW    = 64;
    localparam int SumW     = 67;
    localparam int NumW     = SumW + 16;
    localparam int RemW     = SumW + 32;
    localparam int QuotW    = 32;
    localparam int DivSteps = 32;
    localparam int NumRegs  = 8;
    localparam int AddrW    = 6;
    localparam int CfgW     = 64;
    localparam int Lanes    = 3;

    localparam logic [CfgW-1:0] RegReset [NumRegs] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000,
        64'h0, 64'h0001_0000_0000_0000
    };

    localparam logic [QuotW-1:0] PosLim = 32'h7FFF_FFFF;
    localparam logic [QuotW-1:0] NegLim = 32'h8000_0000;
endpackage
`default_nettype wire

// ===== src/ptp_if.sv =====
// Valid/ready channels for input points and transformed results.
`default_nettype none
interface ptp_in_if;
    logic                        valid;
    logic                        ready;
    logic signed [ptp_pkg::CoordW-1:0] in_x;
    logic signed [ptp_pkg::CoordW-1:0] in_y;
    logic signed [ptp_pkg::CoordW-1:0] in_z;
    modport source (output valid, in_x, in_y, in_z, input ready);
    modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface ptp_out_if;
    logic                        valid;
    logic                        ready;
    logic signed [ptp_pkg::CoordW-1:0] out_x;
    logic signed [ptp_pkg::CoordW-1:0] out_y;
    logic signed [ptp_pkg::CoordW-1:0] out_z;
    logic                        zero_w;
    logic                        saturated;
    modport source (output valid, out_x, out_y, out_z, zero_w, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, zero_w, saturated, output ready);
endinterface
`default_nettype wire

// ===== src/point_transform_perspective_unit.sv =====
// Usage notes:
// Points (in_x, in_y, in_z, signed Q16.16) enter on pt_in, results leave on
// pt_out; both are valid/ready channels, an item moves when both are high.
// The 4x4 matrix sits in eight 64-bit APB registers at byte address 8*i,
// two Q16.16 elements each, lower column in the low half; reset loads the
// identity. Write the matrix only while no item is in flight.
// From accept to result an item passes one multiply stage, one sum stage,
// one magnitude stage, one overflow check stage, 32 restoring divide stages
// (one quotient bit each) and the output register.
// Throughput is one item per cycle unless the receiver stalls; the whole pipe advances together.
// When the receiver stalls with a result waiting, every stage holds and
// pt_in.ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits and the matrix returns to identity.
// A zero w gives zero outputs with zero_w set; quotients beyond Q16.16
// clamp and set saturated.
`default_nettype none
module point_transform_perspective_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ptp_pkg::AddrW-1:0]    paddr,
    input  wire logic [ptp_pkg::CfgW-1:0]     pwdata,
    output logic      [ptp_pkg::CfgW-1:0]     prdata,
    output logic                              pready,
    ptp_in_if.sink                            pt_in,
    ptp_out_if.source                         pt_out
);
    localparam int S = ptp_pkg::SumW;
    localparam int R = ptp_pkg::RemW;
    localparam int L = ptp_pkg::Lanes;
    localparam int D = ptp_pkg::DivSteps;

    logic [ptp_pkg::CfgW-1:0] cfg_reg [ptp_pkg::NumRegs];
    logic signed [31:0] m [4][4];
    logic adv;

    assign pready = 1'b1;
    assign prdata = cfg_reg[paddr[5:3]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ptp_pkg::NumRegs; i++)
                cfg_reg[i] <= ptp_pkg::RegReset[i];
        end
        else if (psel && penable && pwrite)
        begin
            cfg_reg[paddr[5:3]] <= pwdata;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                m[r][c] = (c % 2 == 1) ? $signed(cfg_reg[r*2 + c/2][63:32])
                                       : $signed(cfg_reg[r*2 + c/2][31:0]);
            end
        end
    end

    // advance the whole pipe unless a finished result is stuck at the output
    assign adv = !pt_out.valid || pt_out.ready;
    assign pt_in.ready = adv;

    // stage 1: products
    logic               v1_reg;
    logic signed [63:0] prod_reg [4][3];
    // stage 2: column sums
    logic               v2_reg;
    logic signed [S-1:0] sum_reg [4];
    // stage 3: magnitudes
    logic               v3_reg;
    logic [S-1:0]       den3_reg;
    logic [ptp_pkg::NumW-1:0] num3_reg [L];
    logic               neg3_reg [L];
    logic               zero3_reg;
    // divide pipe, index 0 is the overflow-check stage
    logic               dv_reg   [D+1];
    logic [R-1:0]       rem_reg  [D+1][L];
    logic [31:0]        q_reg    [D+1][L];
    logic               ovf_reg  [D+1][L];
    logic               neg_reg  [D+1][L];
    logic               zero_reg [D+1];
    logic [S-1:0]       den_reg  [D+1];
    // output
    logic               ov_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic               ozero_reg, osat_reg;

    logic signed [S-1:0] sum_next [4];
    logic [R-1:0]        rem_next [D+1][L];
    logic [31:0]         q_next   [D+1][L];
    logic [31:0]         mag_next [L];
    logic [31:0]         res_next [L];
    logic                sat_next;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum_next[c] = S'(prod_reg[c][0]) + S'(prod_reg[c][1]) + S'(prod_reg[c][2])
                        + (S'(m[3][c]) <<< 16);
        end
        for (int k = 1; k <= D; k++)
        begin
            for (int l = 0; l < L; l++)
            begin
                logic [R-1:0] dsh;
                dsh = R'(den_reg[k-1]) << (D - k);
                if (rem_reg[k-1][l] >= dsh)
                begin
                    rem_next[k][l] = rem_reg[k-1][l] - dsh;
                    q_next[k][l]   = q_reg[k-1][l] | (32'd1 << (D - k));
                end
                else
                begin
                    rem_next[k][l] = rem_reg[k-1][l];
                    q_next[k][l]   = q_reg[k-1][l];
                end
            end
        end
        rem_next[0] = rem_reg[0];
        q_next[0]   = q_reg[0];
        sat_next = 1'b0;
        for (int l = 0; l < L; l++)
        begin
            logic [31:0] lim;
            lim = neg_reg[D][l] ? ptp_pkg::NegLim : ptp_pkg::PosLim;
            if (ovf_reg[D][l] || q_reg[D][l] > lim)
            begin
                mag_next[l] = lim;
                sat_next    = 1'b1;
            end
            else
            begin
                mag_next[l] = q_reg[D][l];
            end
            res_next[l] = neg_reg[D][l] ? (32'd0 - mag_next[l]) : mag_next[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
            for (int k = 0; k <= D; k++)
                dv_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pt_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            dv_reg[0] <= v3_reg;
            for (int k = 1; k <= D; k++)
                dv_reg[k] <= dv_reg[k-1];
            ov_reg <= dv_reg[D];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_reg[c][0] <= pt_in.in_x * m[0][c];
                prod_reg[c][1] <= pt_in.in_y * m[1][c];
                prod_reg[c][2] <= pt_in.in_z * m[2][c];
                sum_reg[c]     <= sum_next[c];
            end
            den3_reg  <= sum_reg[3][S-1] ? S'(-sum_reg[3]) : S'(sum_reg[3]);
            zero3_reg <= (sum_reg[3] == '0);
            for (int l = 0; l < L; l++)
            begin
                logic [S-1:0] mg;
                mg = sum_reg[l][S-1] ? S'(-sum_reg[l]) : S'(sum_reg[l]);
                num3_reg[l] <= {mg, 16'b0};
                neg3_reg[l] <= sum_reg[l][S-1] ^ sum_reg[3][S-1];
            end
            // overflow when the quotient needs more than 32 bits
            den_reg[0]  <= den3_reg;
            zero_reg[0] <= zero3_reg;
            for (int l = 0; l < L; l++)
            begin
                rem_reg[0][l] <= R'(num3_reg[l]);
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= neg3_reg[l];
                ovf_reg[0][l] <= (R'(num3_reg[l]) >= {den3_reg, 32'b0});
            end
            for (int k = 1; k <= D; k++)
            begin
                den_reg[k]  <= den_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                for (int l = 0; l < L; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    q_reg[k][l]   <= q_next[k][l];
                    neg_reg[k][l] <= neg_reg[k-1][l];
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                end
            end
            if (zero_reg[D])
            begin
                ox_reg    <= '0;
                oy_reg    <= '0;
                oz_reg    <= '0;
                ozero_reg <= 1'b1;
                osat_reg  <= 1'b0;
            end
            else
            begin
                ox_reg    <= $signed(res_next[0]);
                oy_reg    <= $signed(res_next[1]);
                oz_reg    <= $signed(res_next[2]);
                ozero_reg <= 1'b0;
                osat_reg  <= sat_next;
            end
        end
    end

    assign pt_out.valid     = ov_reg;
    assign pt_out.out_x     = ox_reg;
    assign pt_out.out_y     = oy_reg;
    assign pt_out.out_z     = oz_reg;
    assign pt_out.zero_w    = ozero_reg;
    assign pt_out.saturated = osat_reg;
endmodule
`default_nettype wire
